/* rtl/tti_pkg.sv */
// tti_pkg: shared types and codes for the timestamp table interpolator
// no dependencies
`timescale 1ns / 1ps

package tti_pkg;

    localparam int unsigned TIME_W = 48;
    localparam int unsigned VAL_W  = 16;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam logic [2:0] ST_DONE   = 3'd0;
    localparam logic [2:0] ST_REJECT = 3'd1;
    localparam logic [2:0] ST_EXACT  = 3'd2;
    localparam logic [2:0] ST_INTERP = 3'd3;
    localparam logic [2:0] ST_OOR    = 3'd4;

    typedef struct packed {
        logic [1:0]        mode;
        logic [47:0]       sample_time;
        logic signed [15:0] vec_x;
        logic signed [15:0] vec_y;
        logic signed [15:0] vec_z;
        logic [15:0]       confidence_spread;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic signed [15:0] out_x;
        logic signed [15:0] out_y;
        logic signed [15:0] out_z;
        logic [15:0]       out_spread;
    } out_item_t;

endpackage

/* rtl/tti_lerp.sv */
// tti_lerp: one-component fixed point blend e0 + ((e1-e0)*frac + 2^15) >>> 16
// no dependencies (widths are written by value)
`timescale 1ns / 1ps

module tti_lerp
(
    input  logic        clk,
    input  logic        signed_mode,
    input  logic [15:0] e0,
    input  logic [15:0] e1,
    input  logic [15:0] frac,
    output logic [15:0] result
);

    logic signed [17:0] e0_ext;
    logic signed [17:0] e1_ext;
    logic signed [17:0] diff;
    logic signed [35:0] prod_next;
    logic signed [35:0] prod_reg;
    logic signed [17:0] e0_reg;
    logic signed [35:0] rounded;

    // operand extension by signedness, then difference and product with frac
    always_comb
    begin
        e0_ext = signed_mode ? {{2{e0[15]}}, e0} : {2'b00, e0};
        e1_ext = signed_mode ? {{2{e1[15]}}, e1} : {2'b00, e1};
        diff = e1_ext - e0_ext;
        prod_next = diff * $signed({2'b00, frac});
    end

    // register the product and the extended base
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        e0_reg   <= e0_ext;
    end

    // round, shift and add the base
    always_comb
    begin
        rounded = (prod_reg + 36'sd32768) >>> 16;
        result = 16'(rounded[17:0] + e0_reg);
    end

endmodule

/* rtl/timestamp_table_interpolator.sv */
// timestamp_table_interpolator: sorted sample table with lookup and interpolation
// depends on tti_pkg and tti_lerp
// clear, mode 3 and an empty-table query end from idle; a load goes through S_LOAD; a query
// checks the first, then the last entry (out of range ends there), then a lower-bound search
// of up to ceil(log2(count)) steps; an exact hit ends at S_SCMP, an interpolated one goes on
// through S_PAIR2, a 16-step restoring divider that forms the fraction, S_MUL and S_OUT.
// start is taken only while busy is low, so the next beat goes in the result cycle;
// done pulses for one cycle with result and the receiver cannot stall.
// reset empties the table; memory contents are not cleared.
`timescale 1ns / 1ps

module timestamp_table_interpolator
#(
    parameter int unsigned TABLE_DEPTH = 1024
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  tti_pkg::in_item_t  item,
    output logic               busy,
    output logic               done,
    output tti_pkg::out_item_t result
);

    localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_LOAD   = 11'b00000000010,
        S_QFIRST = 11'b00000000100,
        S_QLAST  = 11'b00000001000,
        S_SRD    = 11'b00000010000,
        S_SCMP   = 11'b00000100000,
        S_PAIR   = 11'b00001000000,
        S_PAIR2  = 11'b00010000000,
        S_DIV    = 11'b00100000000,
        S_MUL    = 11'b01000000000,
        S_OUT    = 11'b10000000000
    } state_t;

    // storage
    logic [47:0] time_mem   [TABLE_DEPTH];
    logic [63:0] sample_mem [TABLE_DEPTH];

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg;
    tti_pkg::in_item_t   item_reg;
    logic [AW-1:0]       lo_reg, hi_reg, mid;
    logic [AW-1:0]       raddr;
    logic [47:0]         t_rd;
    logic [63:0]         s_rd;
    logic [63:0]         s0_reg, s1_reg;
    logic [47:0]         span_reg;
    logic [63:0]         rem_reg;
    logic [15:0]         quo_reg;
    logic [5:0]          step_reg;
    logic [64:0]         trial;
    logic [15:0]         lx, ly, lz, ls;
    logic [AW-1:0]       last_idx;

    assign last_idx = AW'(count_reg - CW'(1));
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign busy = (state_reg != S_IDLE);

    // read address selection
    always_comb
    begin
        case (state_reg)
            S_IDLE:   raddr = (start && item.mode == tti_pkg::MODE_QUERY) ? '0 : last_idx;
            S_QFIRST: raddr = last_idx;
            S_SRD:    raddr = mid;
            S_SCMP:   raddr = lo_reg - AW'(1);
            default:  raddr = lo_reg;
        endcase
    end

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        t_rd <= time_mem[raddr];
        s_rd <= sample_mem[raddr];
        if (state_reg == S_LOAD && count_reg != CW'(TABLE_DEPTH)
            && !(count_reg != '0 && item_reg.sample_time <= t_rd))
        begin
            time_mem[count_reg[AW-1:0]]   <= item_reg.sample_time;
            sample_mem[count_reg[AW-1:0]] <= {item_reg.confidence_spread, item_reg.vec_z,
                                              item_reg.vec_y, item_reg.vec_x};
        end
    end

    // divider trial subtract
    assign trial = {rem_reg, 1'b0} - {17'd0, span_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && item.mode == tti_pkg::MODE_LOAD)
                    state_next = S_LOAD;
                else if (start && item.mode == tti_pkg::MODE_QUERY && count_reg != '0)
                    state_next = S_QFIRST;
            end
            S_LOAD:   state_next = S_IDLE;
            S_QFIRST: state_next = (item_reg.sample_time < t_rd) ? S_IDLE : S_QLAST;
            S_QLAST:  state_next = (item_reg.sample_time > t_rd) ? S_IDLE : S_SRD;
            // lower bound step on the time read at mid
            S_SRD:    state_next = (lo_reg == hi_reg) ? S_SCMP : S_PAIR;
            S_PAIR:   state_next = S_SRD;
            S_SCMP:   state_next = (t_rd == item_reg.sample_time) ? S_IDLE : S_PAIR2;
            S_PAIR2:  state_next = S_DIV;
            S_DIV:    state_next = (step_reg == 6'd15) ? S_MUL : S_DIV;
            S_MUL:    state_next = S_OUT;
            S_OUT:    state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // control and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // every beat ends with one return to idle
            done      <= (state_next == S_IDLE) && (busy || start);
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        item_reg <= item;
                        if (item.mode == tti_pkg::MODE_QUERY && count_reg == '0)
                            result <= {tti_pkg::ST_OOR, 64'd0};
                        else
                            result <= '0;
                        if (item.mode == tti_pkg::MODE_CLEAR)
                            count_reg <= '0;
                    end
                end
                S_LOAD:
                begin
                    if (count_reg == CW'(TABLE_DEPTH)
                        || (count_reg != '0 && item_reg.sample_time <= t_rd))
                        result.status <= tti_pkg::ST_REJECT;
                    else
                        count_reg <= count_reg + CW'(1);
                end
                S_QFIRST:
                begin
                    if (item_reg.sample_time < t_rd)
                        result.status <= tti_pkg::ST_OOR;
                end
                S_QLAST:
                begin
                    lo_reg <= '0;
                    hi_reg <= last_idx;
                    if (item_reg.sample_time > t_rd)
                        result.status <= tti_pkg::ST_OOR;
                end
                S_PAIR:
                begin
                    if (t_rd < item_reg.sample_time)
                        lo_reg <= mid + AW'(1);
                    else
                        hi_reg <= mid;
                end
                S_SCMP:
                begin
                    // t_rd, s_rd now hold entry lo
                    if (t_rd == item_reg.sample_time)
                    begin
                        result.status <= tti_pkg::ST_EXACT;
                        result.out_x <= s_rd[15:0];
                        result.out_y <= s_rd[31:16];
                        result.out_z <= s_rd[47:32];
                        result.out_spread <= s_rd[63:48];
                    end
                    else
                    begin
                        span_reg <= t_rd;
                        s1_reg <= s_rd;
                    end
                end
                S_PAIR2:
                begin
                    // t_rd, s_rd now hold entry lo - 1
                    s0_reg <= s_rd;
                    span_reg <= span_reg - t_rd;
                    rem_reg <= {16'd0, item_reg.sample_time - t_rd};
                    quo_reg <= '0;
                    step_reg <= '0;
                end
                S_DIV:
                begin
                    // restoring division of (t - t0) << 16 by span, bit per cycle
                    if (!trial[64])
                    begin
                        rem_reg <= trial[63:0];
                        quo_reg <= {quo_reg[14:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[62:0], 1'b0};
                        quo_reg <= {quo_reg[14:0], 1'b0};
                    end
                    step_reg <= step_reg + 6'd1;
                end
                S_OUT:
                begin
                    result.status <= tti_pkg::ST_INTERP;
                    result.out_x <= lx;
                    result.out_y <= ly;
                    result.out_z <= lz;
                    result.out_spread <= ls;
                end
                default: ;
            endcase
        end
    end

    tti_lerp u_lx (.clk(clk), .signed_mode(1'b1), .e0(s0_reg[15:0]),  .e1(s1_reg[15:0]),
                   .frac(quo_reg), .result(lx));
    tti_lerp u_ly (.clk(clk), .signed_mode(1'b1), .e0(s0_reg[31:16]), .e1(s1_reg[31:16]),
                   .frac(quo_reg), .result(ly));
    tti_lerp u_lz (.clk(clk), .signed_mode(1'b1), .e0(s0_reg[47:32]), .e1(s1_reg[47:32]),
                   .frac(quo_reg), .result(lz));
    tti_lerp u_ls (.clk(clk), .signed_mode(1'b0), .e0(s0_reg[63:48]), .e1(s1_reg[63:48]),
                   .frac(quo_reg), .result(ls));

    // checks
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg)) else $error("state not one-hot");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH)) else $error("count overflow");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == S_IDLE) else $error("done while busy");

endmodule

/* dv/tb.sv */
// tb: self-checking testbench for timestamp_table_interpolator
// drives clear, load, query and spare-mode beats and checks each result against a local table predictor
// depends on tti_pkg and the rtl of the block
`timescale 1ns / 1ps

module tb;

    localparam int unsigned DEPTH = 1024;
    localparam logic [1:0]  MODE_SPARE = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               start;
    tti_pkg::in_item_t  item;
    logic               busy;
    logic               done;
    tti_pkg::out_item_t result;

    timestamp_table_interpolator #(.TABLE_DEPTH(DEPTH)) u_top
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    // predictor state: shadow of the sample table
    logic [47:0] shadow_time [DEPTH];
    logic [15:0] shadow_x [DEPTH];
    logic [15:0] shadow_y [DEPTH];
    logic [15:0] shadow_z [DEPTH];
    logic [15:0] shadow_spread [DEPTH];
    int unsigned shadow_count;

    tti_pkg::out_item_t pending_results[$];
    int                 error_count;
    int                 sender_idle_pct;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report_mismatch(input string what);
        error_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // linear blend of two 16-bit values, round-half-up of the scaled delta
    function automatic logic [15:0] blend(input longint e0, input longint e1,
                                          input longint frac);
        longint p;
        longint q;
        p = (e1 - e0) * frac + 32768;
        q = p >>> 16;
        return 16'(e0 + q);
    endfunction

    function automatic tti_pkg::out_item_t predict_lookup(input tti_pkg::in_item_t it);
        tti_pkg::out_item_t r;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int unsigned a;
        logic [63:0] frac64;
        longint      frac;
        r = '0;
        r.status = tti_pkg::ST_DONE;
        case (it.mode)
            tti_pkg::MODE_CLEAR: shadow_count = 0;
            tti_pkg::MODE_LOAD:
            begin
                if (shadow_count >= DEPTH ||
                    (shadow_count > 0 && it.sample_time <= shadow_time[shadow_count-1]))
                    r.status = tti_pkg::ST_REJECT;
                else
                begin
                    shadow_time[shadow_count]   = it.sample_time;
                    shadow_x[shadow_count]      = it.vec_x;
                    shadow_y[shadow_count]      = it.vec_y;
                    shadow_z[shadow_count]      = it.vec_z;
                    shadow_spread[shadow_count] = it.confidence_spread;
                    shadow_count++;
                end
            end
            tti_pkg::MODE_QUERY:
            begin
                if (shadow_count == 0 || it.sample_time < shadow_time[0] ||
                    it.sample_time > shadow_time[shadow_count-1])
                    r.status = tti_pkg::ST_OOR;
                else
                begin
                    lo = 0;
                    hi = shadow_count - 1;
                    while (lo < hi)
                    begin
                        mid = lo + ((hi - lo) >> 1);
                        if (shadow_time[mid] < it.sample_time) lo = mid + 1;
                        else hi = mid;
                    end
                    if (shadow_time[lo] == it.sample_time)
                    begin
                        r.status     = tti_pkg::ST_EXACT;
                        r.out_x      = shadow_x[lo];
                        r.out_y      = shadow_y[lo];
                        r.out_z      = shadow_z[lo];
                        r.out_spread = shadow_spread[lo];
                    end
                    else
                    begin
                        a = lo - 1;
                        frac64 = ({16'd0, it.sample_time - shadow_time[a]} << 16) /
                                 {16'd0, shadow_time[lo] - shadow_time[a]};
                        frac = longint'(frac64[15:0]);
                        r.status     = tti_pkg::ST_INTERP;
                        r.out_x      = blend(longint'($signed(shadow_x[a])),
                                             longint'($signed(shadow_x[lo])), frac);
                        r.out_y      = blend(longint'($signed(shadow_y[a])),
                                             longint'($signed(shadow_y[lo])), frac);
                        r.out_z      = blend(longint'($signed(shadow_z[a])),
                                             longint'($signed(shadow_z[lo])), frac);
                        r.out_spread = blend(longint'(shadow_spread[a]),
                                             longint'(shadow_spread[lo]), frac);
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // one beat: idle gap, raise start, wait for acceptance and for busy to fall
    task automatic send_beat(input tti_pkg::in_item_t it);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        item  <= it;
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        pending_results = {pending_results, predict_lookup(it)};
        @(negedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        tti_pkg::out_item_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                if (result.status !== want.status)
                    report_mismatch($sformatf("status %0d want %0d", result.status, want.status));
                if (result.out_x !== want.out_x)
                    report_mismatch($sformatf("out_x %h want %h", result.out_x, want.out_x));
                if (result.out_y !== want.out_y)
                    report_mismatch($sformatf("out_y %h want %h", result.out_y, want.out_y));
                if (result.out_z !== want.out_z)
                    report_mismatch($sformatf("out_z %h want %h", result.out_z, want.out_z));
                if (result.out_spread !== want.out_spread)
                    report_mismatch($sformatf("out_spread %h want %h",
                                              result.out_spread, want.out_spread));
            end
        end
    end

    function automatic tti_pkg::in_item_t make_item(input logic [1:0] m, input logic [47:0] t,
                                                    input logic [15:0] x, input logic [15:0] y,
                                                    input logic [15:0] z, input logic [15:0] s);
        tti_pkg::in_item_t it;
        it.mode = m;
        it.sample_time = t;
        it.vec_x = x;
        it.vec_y = y;
        it.vec_z = z;
        it.confidence_spread = s;
        return it;
    endfunction

    function automatic logic [15:0] rand16();
        case ($urandom_range(3))
            0: return 16'h8000;
            1: return 16'h7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    // directed table: beat plus a fixed status where it is obvious
    typedef struct {
        tti_pkg::in_item_t beat;
        logic              has_status;
        logic [2:0]        fixed_status;
    } directed_row_t;

    directed_row_t directed_rows[$];

    task automatic add_row(input tti_pkg::in_item_t it, input logic has, input logic [2:0] st);
        directed_row_t row;
        row.beat = it;
        row.has_status = has;
        row.fixed_status = st;
        directed_rows = {directed_rows, row};
    endtask

    initial
    begin
        logic [47:0]        tnow;
        tti_pkg::in_item_t  it;
        int                 n_loaded;
        tti_pkg::out_item_t want;
        start = 1'b0;
        item  = '0;
        rst_n = 1'b0;
        error_count = 0;
        shadow_count = 0;
        sender_idle_pct = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty table, extremes, each mode and rejection cases
        add_row(make_item(tti_pkg::MODE_QUERY, 48'd0, '0, '0, '0, '0), 1'b1, tti_pkg::ST_OOR);
        add_row(make_item(tti_pkg::MODE_QUERY, '1, '1, '1, '1, '1), 1'b1, tti_pkg::ST_OOR);
        add_row(make_item(MODE_SPARE, '1, '1, '1, '1, '1), 1'b1, tti_pkg::ST_DONE);
        add_row(make_item(tti_pkg::MODE_LOAD, 48'd1000, 16'h8000, 16'h7fff, 16'h0000, 16'hffff),
                1'b1, tti_pkg::ST_DONE);
        add_row(make_item(tti_pkg::MODE_QUERY, 48'd1001, '0, '0, '0, '0), 1'b1, tti_pkg::ST_OOR);
        add_row(make_item(tti_pkg::MODE_QUERY, 48'd1000, '0, '0, '0, '0),
                1'b0, tti_pkg::ST_EXACT);
        add_row(make_item(tti_pkg::MODE_LOAD, 48'd1000, '0, '0, '0, '0),
                1'b1, tti_pkg::ST_REJECT);
        add_row(make_item(tti_pkg::MODE_LOAD, 48'd999, '0, '0, '0, '0),
                1'b1, tti_pkg::ST_REJECT);
        add_row(make_item(tti_pkg::MODE_LOAD, 48'd3000, 16'h7fff, 16'h8000, 16'hffff, 16'h0000),
                1'b1, tti_pkg::ST_DONE);
        add_row(make_item(tti_pkg::MODE_QUERY, 48'd2000, '0, '0, '0, '0),
                1'b0, tti_pkg::ST_INTERP);
        add_row(make_item(tti_pkg::MODE_QUERY, 48'd1001, '0, '0, '0, '0),
                1'b0, tti_pkg::ST_INTERP);
        add_row(make_item(tti_pkg::MODE_QUERY, 48'd2999, '0, '0, '0, '0),
                1'b0, tti_pkg::ST_INTERP);
        add_row(make_item(tti_pkg::MODE_QUERY, 48'd999, '0, '0, '0, '0), 1'b1, tti_pkg::ST_OOR);
        add_row(make_item(tti_pkg::MODE_QUERY, 48'd3001, '0, '0, '0, '0), 1'b1, tti_pkg::ST_OOR);
        add_row(make_item(tti_pkg::MODE_LOAD, '1, 16'h1234, 16'hedcb, 16'h0001, 16'h8000),
                1'b1, tti_pkg::ST_DONE);
        add_row(make_item(tti_pkg::MODE_QUERY, 48'h8000_0000_0000, '0, '0, '0, '0),
                1'b0, tti_pkg::ST_INTERP);
        add_row(make_item(tti_pkg::MODE_QUERY, '1, '0, '0, '0, '0), 1'b0, tti_pkg::ST_EXACT);
        add_row(make_item(tti_pkg::MODE_CLEAR, '1, '1, '1, '1, '1), 1'b1, tti_pkg::ST_DONE);
        add_row(make_item(tti_pkg::MODE_QUERY, 48'd1000, '0, '0, '0, '0), 1'b1, tti_pkg::ST_OOR);
        add_row(make_item(tti_pkg::MODE_LOAD, 48'd0, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa),
                1'b1, tti_pkg::ST_DONE);
        add_row(make_item(tti_pkg::MODE_LOAD, 48'd1, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555),
                1'b1, tti_pkg::ST_DONE);
        add_row(make_item(tti_pkg::MODE_QUERY, 48'd0, '0, '0, '0, '0), 1'b0, tti_pkg::ST_EXACT);
        add_row(make_item(tti_pkg::MODE_QUERY, 48'd1, '0, '0, '0, '0), 1'b0, tti_pkg::ST_EXACT);

        foreach (directed_rows[i])
        begin
            send_beat(directed_rows[i].beat);
            want = pending_results[$];
            if (directed_rows[i].has_status && want.status !== directed_rows[i].fixed_status)
                report_mismatch($sformatf("directed row %0d predicted status %0d", i, want.status));
        end

        // random tables of modest size, mostly valid queries
        for (int phase = 0; phase < 4; phase++)
        begin
            sender_idle_pct = (phase == 1) ? 47 : (phase == 3) ? 11 : 0;
            for (int rep = 0; rep < 5; rep++)
            begin
                send_beat(make_item(tti_pkg::MODE_CLEAR, 48'({$urandom, $urandom}),
                                    '0, '0, '0, '0));
                tnow = ($urandom_range(3) == 0) ? 48'({$urandom, $urandom} >> $urandom_range(47))
                                                 : 48'($urandom_range(100));
                n_loaded = $urandom_range(1, 12);
                for (int k = 0; k < n_loaded; k++)
                begin
                    if (k > 0)
                        tnow += ($urandom_range(3) == 0) ? 48'({$urandom, $urandom} >> 20)
                                                         : 48'($urandom_range(1, 5000));
                    if ($urandom_range(9) == 0)
                        it = make_item(tti_pkg::MODE_LOAD, tnow - 48'($urandom_range(2)),
                                       rand16(), rand16(), rand16(), rand16());
                    else
                        it = make_item(tti_pkg::MODE_LOAD, tnow,
                                       rand16(), rand16(), rand16(), rand16());
                    send_beat(it);
                end
                for (int k = 0; k < 14; k++)
                begin
                    if (shadow_count > 0 && $urandom_range(9) < 8)
                        it = make_item(tti_pkg::MODE_QUERY,
                                       shadow_time[0] + 48'(({$urandom, $urandom}) %
                                       ({16'd0, shadow_time[shadow_count-1] - shadow_time[0]} + 1)),
                                       rand16(), rand16(), rand16(), rand16());
                    else if ($urandom_range(3) == 0 && shadow_count > 0)
                        it = make_item(tti_pkg::MODE_QUERY,
                                       shadow_time[$urandom_range(shadow_count-1)],
                                       '0, '0, '0, '0);
                    else
                        it = make_item(2'($urandom_range(3)), 48'({$urandom, $urandom}),
                                       rand16(), rand16(), rand16(), rand16());
                    send_beat(it);
                end
            end
        end

        // drain
        start <= 1'b0;
        fork
            begin
                while (pending_results.size() != 0) @(posedge clk);
                repeat (200) @(posedge clk);
            end
            begin
                repeat (20000) @(posedge clk);
                error_count++;
                $display("drain timed out");
            end
        join_any
        disable fork;

        if (error_count == 0)
            $display("timestamp_table_interpolator regression: pass");
        else
            $display("timestamp_table_interpolator regression: fail");
        $finish;
    end

    // overall watchdog
    initial
    begin
        #20ms;
        $display("timestamp_table_interpolator regression: fail");
        $finish;
    end

endmodule

/* timestamp_table_interpolator.f */
rtl/tti_pkg.sv
rtl/tti_lerp.sv
rtl/timestamp_table_interpolator.sv
dv/tb.sv
